### hdl/exlex_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exlex_pkg: shared types, codes and character classes
// Request payloads, scanner states, token kinds and small character tests
// used by the two-dialect expression lexer.
// ----------------------------------------------------------------------------
package exlex_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } exlex_in_t;

  typedef struct packed {
    logic [7:0] tagged_char;
    logic       in_token;
    logic       keep_char;
    logic       token_first;
    logic       token_last;
    logic [2:0] token_kind;
    logic [1:0] error_code;
    logic       stream_done;
  } exlex_out_t;

  // Per-character tags from the classifier
  typedef struct packed {
    logic       in_token;
    logic       keep_char;
    logic       token_first;
    logic       token_last;
    logic [2:0] token_kind;
  } exlex_tag_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DOTS, S_ALPHA, S_OPER, S_UNDER, S_NINT, S_NFRAC, S_NEXP,
    S_NEXPD, S_STR, S_STRESC, S_BOPEN, S_BLK, S_BSTAR, S_LOPEN, S_LINE
  } scan_state_t;

  localparam logic [2:0] KIND_PUNCT = 3'd0;
  localparam logic [2:0] KIND_DOTS  = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_ALPHA = 3'd3;
  localparam logic [2:0] KIND_OPER  = 3'd4;
  localparam logic [2:0] KIND_UNDER = 3'd5;
  localparam logic [2:0] KIND_NUM   = 3'd6;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam logic CFG_DIALECT = 1'b0;
  localparam logic CFG_EXP_EN  = 1'b1;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_QUOTE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_sym(input logic [7:0] c);
    return (c == "~") || (c == CH_BTICK) || (c == "!") || (c == "@") || (c == "#") ||
           (c == "$") || (c == "^") || (c == "&") || (c == "*") || (c == "-") ||
           (c == "=") || (c == "+") || (c == ":") || (c == "<") || (c == ">") ||
           (c == "?") || (c == "/") || (c == CH_BSLASH) || (c == "|");
  endfunction

  function automatic logic is_exp(input logic [7:0] c, input logic exp_en);
    return exp_en && ((c == "e") || (c == "E"));
  endfunction

  function automatic logic is_punct(input logic [7:0] c, input logic dialect);
    logic r;
    case (c)
      "(", ")", "{", "}", "[", "]", ",", "%": r = 1'b1;
      ";":      r = ~dialect;
      CH_QUOTE: r = dialect;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  // True when lookahead p continues a token in state st
  function automatic logic goes_on(input scan_state_t st, input logic pv,
                                   input logic [7:0] p, input logic dialect,
                                   input logic exp_en);
    logic r;
    case (st)
      S_DOTS:  r = (p == ".");
      S_ALPHA: r = dialect ? (is_alnum(p) || is_sym(p)) : is_alnum(p);
      S_OPER:  r = dialect ? (is_alnum(p) || is_sym(p)) : is_sym(p);
      S_UNDER: r = (p == "_");
      S_NINT:  r = is_digit(p) || (p == ".") || is_exp(p, exp_en);
      S_NFRAC: r = is_digit(p) || is_exp(p, exp_en);
      S_NEXP:  r = is_digit(p) || (p == "+") || (p == "-");
      S_NEXPD: r = is_digit(p);
      default: r = 1'b0;
    endcase
    return pv && r;
  endfunction

  function automatic logic [2:0] kind_of(input scan_state_t st);
    logic [2:0] k;
    case (st)
      S_DOTS:           k = KIND_DOTS;
      S_ALPHA:          k = KIND_ALPHA;
      S_OPER:           k = KIND_OPER;
      S_UNDER:          k = KIND_UNDER;
      S_STR, S_STRESC:  k = KIND_STR;
      default:          k = KIND_NUM;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### hdl/expression_lexer_two_dialect_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// expression_lexer_two_dialect_unit: byte-stream lexer, two dialects
// Tags each source character with token membership, boundaries and kind.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one character (or an end-of-text mark)
//   per request. out_valid/out_stall/out_data carry one tagged character per
//   request. The first character of a stream only fills the lookahead
//   register and gives no result; each later character releases the tag of
//   the one before it. End of text releases the held character (or an empty
//   result) with stream_done set and any error code, and returns to idle.
//   Throughput is one request per cycle while out_stall holds no result: the
//   classifier is one combinational step between the lookahead and result
//   registers. A result appears in the cycle after its releasing request.
//   in_stall rises only while a result waits and out_stall is high; when the
//   receiver takes the result, a new request is accepted in the same cycle.
//   Reset (rst_n low, synchronous) empties the lookahead and result
//   registers, puts the scanner in idle, and sets dialect 0, exponent on.
//   cfg_we writes register cfg_index (0 dialect, 1 exponent enable).
// ----------------------------------------------------------------------------
module expression_lexer_two_dialect_unit
  import exlex_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire exlex_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output exlex_out_t      out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic       cfg_wdata
);

  logic        held_valid_r, held_valid_nxt;
  logic [7:0]  held_char_r, held_char_nxt;
  scan_state_t scan_r, scan_nxt;
  logic        dialect_r, exp_en_r;
  logic        out_valid_r, out_valid_nxt;
  exlex_out_t  out_r, out_nxt;

  exlex_tag_t  tag;
  scan_state_t cls_state_nxt;
  scan_state_t state_after;
  logic        accept;

  exlex_classify u_classify (
    .held_char  (held_char_r),
    .look_valid (~in_data.end_of_text),
    .look_char  (in_data.character),
    .state      (scan_r),
    .dialect    (dialect_r),
    .exp_en     (exp_en_r),
    .tag        (tag),
    .state_nxt  (cls_state_nxt)
  );

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign state_after = held_valid_r ? cls_state_nxt : scan_r;

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_char_nxt  = held_char_r;
    scan_nxt       = scan_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_nxt        = out_r;
    if (accept) begin
      if (in_data.end_of_text) begin
        out_valid_nxt = 1'b1;
        out_nxt       = '0;
        if (held_valid_r) begin
          out_nxt.tagged_char = held_char_r;
          out_nxt.in_token    = tag.in_token;
          out_nxt.keep_char   = tag.keep_char;
          out_nxt.token_first = tag.token_first;
          out_nxt.token_last  = tag.token_last;
          out_nxt.token_kind  = tag.token_kind;
        end
        if ((state_after == S_BOPEN) || (state_after == S_BLK) ||
            (state_after == S_BSTAR)) begin
          out_nxt.error_code = ERR_COMMENT;
        end else if ((state_after == S_STR) || (state_after == S_STRESC)) begin
          out_nxt.error_code = ERR_STRING;
        end else begin
          out_nxt.error_code = ERR_NONE;
        end
        out_nxt.stream_done = 1'b1;
        held_valid_nxt = 1'b0;
        held_char_nxt  = '0;
        scan_nxt       = S_IDLE;
      end else begin
        // the held character is released only once its lookahead arrives
        if (held_valid_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.tagged_char = held_char_r;
          out_nxt.in_token    = tag.in_token;
          out_nxt.keep_char   = tag.keep_char;
          out_nxt.token_first = tag.token_first;
          out_nxt.token_last  = tag.token_last;
          out_nxt.token_kind  = tag.token_kind;
          out_nxt.error_code  = ERR_NONE;
          out_nxt.stream_done = 1'b0;
          scan_nxt            = cls_state_nxt;
        end else begin
          out_valid_nxt = 1'b0;
        end
        held_valid_nxt = 1'b1;
        held_char_nxt  = in_data.character;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_char_r  <= '0;
      scan_r       <= S_IDLE;
      out_valid_r  <= 1'b0;
      dialect_r    <= 1'b0;
      exp_en_r     <= 1'b1;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_char_r  <= held_char_nxt;
      scan_r       <= scan_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we && (cfg_index == CFG_DIALECT)) begin
        dialect_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == CFG_EXP_EN)) begin
        exp_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

### hdl/exlex_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exlex_classify: tag one held character
// Combinational scanner step: takes the held character, its lookahead and
// the scanner state, and gives the character's tags and the next state.
// ----------------------------------------------------------------------------
module exlex_classify
  import exlex_pkg::*;
(
  input  wire logic [7:0]  held_char,
  input  wire logic        look_valid,
  input  wire logic [7:0]  look_char,
  input  wire scan_state_t state,
  input  wire logic        dialect,
  input  wire logic        exp_en,
  output exlex_tag_t       tag,
  output scan_state_t      state_nxt
);

  logic        tok;
  logic        first;
  logic        last;
  logic        keep;
  logic [2:0]  kind;
  scan_state_t ns;
  logic [7:0]  c;
  logic [7:0]  p;
  logic        pv;

  assign c  = held_char;
  assign p  = look_char;
  assign pv = look_valid;

  always_comb begin
    tok   = 1'b0;
    first = 1'b0;
    last  = 1'b0;
    keep  = 1'b1;
    kind  = KIND_PUNCT;
    ns    = S_IDLE;
    case (state)
      S_IDLE: begin
        if (is_punct(c, dialect)) begin
          tok = 1'b1; first = 1'b1; last = 1'b1;
        end else if ((c == ".") && !(pv && is_digit(p))) begin
          tok = 1'b1; first = 1'b1; ns = S_DOTS;
        end else if ((c == "/") && pv && (p == "*")) begin
          ns = S_BOPEN;
        end else if (!dialect && (c == "/") && pv && (p == "/")) begin
          ns = S_LOPEN;
        end else if (dialect && (c == ";")) begin
          ns = S_LINE;
        end else if (c == CH_DQUOTE) begin
          tok = 1'b1; first = 1'b1; kind = KIND_STR; ns = S_STR;
        end else if (is_alpha(c)) begin
          tok = 1'b1; first = 1'b1; ns = S_ALPHA;
        end else if (is_sym(c)) begin
          tok = 1'b1; first = 1'b1; ns = S_OPER;
        end else if (c == "_") begin
          tok = 1'b1; first = 1'b1; ns = S_UNDER;
        end else if (is_digit(c) || (c == ".")) begin
          tok = 1'b1; first = 1'b1; ns = S_NINT;
        end
        // Close a fresh token at once if the lookahead does not extend it
        if (tok && (ns != S_STR) && (ns != S_IDLE)) begin
          kind = kind_of(ns);
          last = !goes_on(ns, pv, p, dialect, exp_en);
          if (last) begin
            ns = S_IDLE;
          end
        end
      end
      S_STR: begin
        tok  = 1'b1;
        kind = KIND_STR;
        if (c == CH_DQUOTE) begin
          last = 1'b1;
          ns   = S_IDLE;
        end else if (c == CH_BSLASH) begin
          keep = 1'b0;
          ns   = S_STRESC;
        end else begin
          ns = S_STR;
        end
      end
      S_STRESC: begin
        tok  = 1'b1;
        kind = KIND_STR;
        ns   = S_STR;
      end
      S_BOPEN: ns = S_BLK;
      S_BLK:   ns = (c == "*") ? S_BSTAR : S_BLK;
      S_BSTAR: ns = (c == "/") ? S_IDLE : ((c == "*") ? S_BSTAR : S_BLK);
      S_LOPEN: ns = S_LINE;
      S_LINE:  ns = (c == CH_NL) ? S_IDLE : S_LINE;
      default: begin
        // continuing dots, atom, operator, underscore or number
        tok  = 1'b1;
        kind = kind_of(state);
        if (state == S_NINT) begin
          ns = is_digit(c) ? S_NINT : ((c == ".") ? S_NFRAC : S_NEXP);
        end else if (state == S_NFRAC) begin
          ns = is_digit(c) ? S_NFRAC : S_NEXP;
        end else if ((state == S_NEXP) || (state == S_NEXPD)) begin
          ns = S_NEXPD;
        end else begin
          ns = state;
        end
        last = !goes_on(ns, pv, p, dialect, exp_en);
        if (last) begin
          ns = S_IDLE;
        end
      end
    endcase
    if (!tok) begin
      keep = 1'b0;
      kind = KIND_PUNCT;
    end
  end

  assign tag.in_token    = tok;
  assign tag.keep_char   = keep;
  assign tag.token_first = first;
  assign tag.token_last  = last;
  assign tag.token_kind  = kind;
  assign state_nxt       = ns;

endmodule
`default_nettype wire
